// ===== sv/csn_pkg.sv =====
// shared types, constants and edge tables for the cube-sphere neighbor unit
// no dependencies
package csn_pkg;

    localparam int MAX_SIDE = 256;
    localparam int SIDE_W   = 9;
    localparam int IDX_W    = 19;
    localparam int REM_W    = 16;
    localparam int CRD_W    = 8;
    localparam int SQ_W     = 17;
    localparam int QUO_BITS = 8;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd16;

    // coordinate selectors
    localparam logic [2:0] SEL_ZERO = 3'd0;
    localparam logic [2:0] SEL_EDGE = 3'd1;
    localparam logic [2:0] SEL_X    = 3'd2;
    localparam logic [2:0] SEL_EX   = 3'd3;
    localparam logic [2:0] SEL_Y    = 3'd4;
    localparam logic [2:0] SEL_EY   = 3'd5;

    // directions
    localparam int DIR_N = 0;
    localparam int DIR_E = 1;
    localparam int DIR_S = 2;
    localparam int DIR_W = 3;

    localparam logic [2:0] FC_FRONT = 3'd0;
    localparam logic [2:0] FC_BACK  = 3'd1;
    localparam logic [2:0] FC_UP    = 3'd2;
    localparam logic [2:0] FC_DOWN  = 3'd3;
    localparam logic [2:0] FC_LEFT  = 3'd4;
    localparam logic [2:0] FC_RIGHT = 3'd5;

    localparam logic [2:0] ADJ_FACE [0:5][0:3] = '{
        '{FC_UP,    FC_RIGHT, FC_DOWN,  FC_LEFT },
        '{FC_UP,    FC_LEFT,  FC_DOWN,  FC_RIGHT},
        '{FC_RIGHT, FC_FRONT, FC_LEFT,  FC_BACK },
        '{FC_LEFT,  FC_FRONT, FC_RIGHT, FC_BACK },
        '{FC_UP,    FC_FRONT, FC_DOWN,  FC_BACK },
        '{FC_UP,    FC_BACK,  FC_DOWN,  FC_FRONT}
    };

    localparam logic [2:0] COL_SEL [0:3][0:5] = '{
        '{SEL_EDGE, SEL_ZERO, SEL_EX, SEL_X,  SEL_X,    SEL_EX  },
        '{SEL_ZERO, SEL_ZERO, SEL_EY, SEL_Y,  SEL_ZERO, SEL_ZERO},
        '{SEL_EDGE, SEL_ZERO, SEL_X,  SEL_EX, SEL_X,    SEL_EX  },
        '{SEL_EDGE, SEL_EDGE, SEL_Y,  SEL_EY, SEL_EDGE, SEL_EDGE}
    };

    localparam logic [2:0] ROW_SEL [0:3][0:5] = '{
        '{SEL_EX, SEL_X,  SEL_ZERO, SEL_EDGE, SEL_EDGE, SEL_ZERO},
        '{SEL_Y,  SEL_Y,  SEL_ZERO, SEL_EDGE, SEL_Y,    SEL_Y   },
        '{SEL_X,  SEL_EX, SEL_ZERO, SEL_EDGE, SEL_ZERO, SEL_EDGE},
        '{SEL_Y,  SEL_Y,  SEL_ZERO, SEL_EDGE, SEL_Y,    SEL_Y   }
    };

    typedef struct packed {
        logic [SIDE_W-1:0]       n;
        logic [6:0][IDX_W-1:0]   mul;   // k * n * n for k = 0..6
    } t_cfg;

    typedef struct packed {
        logic               vld;
        logic               err;
        logic [2:0]         face;
        logic [IDX_W-1:0]   idx;
        logic [REM_W-1:0]   rem;
        logic [CRD_W-1:0]   quo;
    } t_itm;

    function automatic logic [CRD_W-1:0] pick(input logic [2:0] sel,
                                              input logic [CRD_W-1:0] x,
                                              input logic [CRD_W-1:0] y,
                                              input logic [CRD_W-1:0] e);
        logic [CRD_W-1:0] v;
        case (sel)
            SEL_EDGE: v = e;
            SEL_X:    v = x;
            SEL_EX:   v = e - x;
            SEL_Y:    v = y;
            SEL_EY:   v = e - y;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/csn_front.sv =====
// first stage: range check, face split and remainder within the face
// depends on csn_pkg
module csn_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [csn_pkg::IDX_W-1:0] i_idx,
    input  csn_pkg::t_cfg            i_cfg,
    output csn_pkg::t_itm            o_itm
);

    csn_pkg::t_itm r_itm;
    csn_pkg::t_itm n_itm;
    logic [2:0]    w_face;

    always_comb begin
        w_face = 3'd0;
        if (i_idx >= i_cfg.mul[1]) w_face = 3'd1;
        if (i_idx >= i_cfg.mul[2]) w_face = 3'd2;
        if (i_idx >= i_cfg.mul[3]) w_face = 3'd3;
        if (i_idx >= i_cfg.mul[4]) w_face = 3'd4;
        if (i_idx >= i_cfg.mul[5]) w_face = 3'd5;
        n_itm      = '0;
        n_itm.vld  = i_vld;
        // side zero makes mul[6] zero, so every index is flagged
        n_itm.err  = (i_idx >= i_cfg.mul[6]);
        n_itm.face = w_face;
        n_itm.idx  = i_idx;
        n_itm.rem  = csn_pkg::REM_W'(i_idx - i_cfg.mul[w_face]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_itm.vld <= 1'b0;
        end else if (i_en) begin
            r_itm.vld <= n_itm.vld;
        end
        if (i_en) begin
            r_itm.err  <= n_itm.err;
            r_itm.face <= n_itm.face;
            r_itm.idx  <= n_itm.idx;
            r_itm.rem  <= n_itm.rem;
            r_itm.quo  <= n_itm.quo;
        end
    end

    assign o_itm = r_itm;

endmodule

// ===== sv/csn_div.sv =====
// restoring divider, one quotient bit per stage: row = rem / side, col left in rem
// depends on csn_pkg
module csn_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [csn_pkg::SIDE_W-1:0] i_n,
    input  csn_pkg::t_itm i_itm,
    output csn_pkg::t_itm o_itm
);

    csn_pkg::t_itm r_st [csn_pkg::QUO_BITS];

    genvar g;
    generate
        for (g = 0; g < csn_pkg::QUO_BITS; g++) begin : g_stage
            localparam int B = csn_pkg::QUO_BITS - 1 - g;
            csn_pkg::t_itm          w_in;
            csn_pkg::t_itm          n_st;
            logic [csn_pkg::SQ_W-1:0] w_sh;
            if (g == 0) begin : g_first
                assign w_in = i_itm;
            end else begin : g_next
                assign w_in = r_st[g-1];
            end
            always_comb begin
                w_sh = csn_pkg::SQ_W'(i_n) << B;
                n_st = w_in;
                if ({1'b0, w_in.rem} >= w_sh) begin
                    n_st.rem    = csn_pkg::REM_W'({1'b0, w_in.rem} - w_sh);
                    n_st.quo[B] = 1'b1;
                end else begin
                    n_st.quo[B] = 1'b0;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[g].vld <= 1'b0;
                end else if (i_en) begin
                    r_st[g].vld <= n_st.vld;
                end
                if (i_en) begin
                    r_st[g].err  <= n_st.err;
                    r_st[g].face <= n_st.face;
                    r_st[g].idx  <= n_st.idx;
                    r_st[g].rem  <= n_st.rem;
                    r_st[g].quo  <= n_st.quo;
                end
            end
        end
    endgenerate

    assign o_itm = r_st[csn_pkg::QUO_BITS-1];

endmodule

// ===== sv/csn_nbr.sv =====
// neighbor stages: edge remap and row product, then final sum into output register
// depends on csn_pkg
module csn_nbr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  csn_pkg::t_cfg i_cfg,
    input  csn_pkg::t_itm i_itm,
    output logic          o_valid,
    output logic [2:0]    o_face_id,
    output logic [7:0]    o_col,
    output logic [7:0]    o_row,
    output logic [18:0]   o_north_index,
    output logic [18:0]   o_east_index,
    output logic [18:0]   o_south_index,
    output logic [18:0]   o_west_index,
    output logic          o_range_error
);

    localparam int IW = csn_pkg::IDX_W;
    localparam int CW = csn_pkg::CRD_W;

    // stage a registers
    logic                 r_a_vld;
    logic                 r_a_err;
    logic [2:0]           r_a_face;
    logic [CW-1:0]        r_a_x;
    logic [CW-1:0]        r_a_y;
    logic [3:0]           r_a_edge;
    logic [3:0][IW-1:0]   r_a_in;
    logic [3:0][IW-1:0]   r_a_base;
    logic [3:0][csn_pkg::SQ_W-1:0] r_a_prod;
    logic [3:0][CW-1:0]   r_a_c;

    logic [CW-1:0]        w_x, w_y, w_e;
    logic [3:0]           n_edge;
    logic [3:0][IW-1:0]   n_in;
    logic [3:0][IW-1:0]   n_base;
    logic [3:0][csn_pkg::SQ_W-1:0] n_prod;
    logic [3:0][CW-1:0]   n_c;
    logic [CW-1:0]        w_r [4];

    always_comb begin
        w_x = i_itm.rem[CW-1:0];
        w_y = i_itm.quo;
        w_e = CW'(i_cfg.n - 9'd1);
        n_edge[csn_pkg::DIR_N] = (w_y == '0);
        n_edge[csn_pkg::DIR_E] = (w_x == w_e);
        n_edge[csn_pkg::DIR_S] = (w_y == w_e);
        n_edge[csn_pkg::DIR_W] = (w_x == '0);
        n_in[csn_pkg::DIR_N] = i_itm.idx - IW'(i_cfg.n);
        n_in[csn_pkg::DIR_E] = i_itm.idx + IW'(1);
        n_in[csn_pkg::DIR_S] = i_itm.idx + IW'(i_cfg.n);
        n_in[csn_pkg::DIR_W] = i_itm.idx - IW'(1);
        for (int d = 0; d < 4; d++) begin
            n_c[d]    = csn_pkg::pick(csn_pkg::COL_SEL[d][i_itm.face], w_x, w_y, w_e);
            w_r[d]    = csn_pkg::pick(csn_pkg::ROW_SEL[d][i_itm.face], w_x, w_y, w_e);
            n_base[d] = i_cfg.mul[csn_pkg::ADJ_FACE[i_itm.face][d]];
            n_prod[d] = csn_pkg::SQ_W'(w_r[d]) * csn_pkg::SQ_W'(i_cfg.n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_itm.vld;
        end
        if (i_en) begin
            r_a_err  <= i_itm.err;
            r_a_face <= i_itm.face;
            r_a_x    <= w_x;
            r_a_y    <= w_y;
            r_a_edge <= n_edge;
            r_a_in   <= n_in;
            r_a_base <= n_base;
            r_a_prod <= n_prod;
            r_a_c    <= n_c;
        end
    end

    // stage b: output register
    logic                 r_vld;
    logic [2:0]           r_face;
    logic [CW-1:0]        r_col, r_row;
    logic [3:0][IW-1:0]   r_nb;
    logic                 r_err;
    logic [3:0][IW-1:0]   n_nb;

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            if (r_a_err) begin
                n_nb[d] = '0;
            end else if (r_a_edge[d]) begin
                n_nb[d] = r_a_base[d] + IW'(r_a_prod[d]) + IW'(r_a_c[d]);
            end else begin
                n_nb[d] = r_a_in[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_a_vld;
        end
        if (i_en) begin
            r_err  <= r_a_err;
            r_face <= r_a_err ? 3'd0 : r_a_face;
            r_col  <= r_a_err ? '0 : r_a_x;
            r_row  <= r_a_err ? '0 : r_a_y;
            r_nb   <= n_nb;
        end
    end

    assign o_valid       = r_vld;
    assign o_face_id     = r_face;
    assign o_col         = r_col;
    assign o_row         = r_row;
    assign o_north_index = r_nb[csn_pkg::DIR_N];
    assign o_east_index  = r_nb[csn_pkg::DIR_E];
    assign o_south_index = r_nb[csn_pkg::DIR_S];
    assign o_west_index  = r_nb[csn_pkg::DIR_W];
    assign o_range_error = r_err;

endmodule

// ===== sv/cube_sphere_cell_neighbors.sv =====
// top level of the cube-sphere neighbor unit: side register, derived constants, pipeline
// depends on csn_pkg, csn_front, csn_div, csn_nbr
//
// usage
//   input channel: i_valid / o_ready with i_cell_index; one request per accepted edge
//   output channel: o_valid / i_ready with face, column, row, four neighbor indices
//     and range_error; out-of-range requests return range_error and zeros elsewhere
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_side (always ready)
// pipeline: 11 register stages from the accepting edge to o_valid (1 face split,
//   8 divider, 2 neighbor)
// throughput: one request per cycle while the output is not stalled and no side write is
//   settling; the 8-stage pipelined restoring divider for the row sets the depth, not the rate
// after a side write, o_ready stays low while side, side*side and its multiples settle
//   in their registers r_n, r_n2 and r_mul
// reset: pipeline valid bits cleared, side back to 16
// receiver stall: the whole pipeline holds in place while o_valid is high and
//   i_ready low; o_ready falls with it, so nothing is lost or repeated
module cube_sphere_cell_neighbors (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [18:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_face_id,
    output logic [7:0]  o_col,
    output logic [7:0]  o_row,
    output logic [18:0] o_north_index,
    output logic [18:0] o_east_index,
    output logic [18:0] o_south_index,
    output logic [18:0] o_west_index,
    output logic        o_range_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_side
);

    // side register and derived values
    logic [csn_pkg::SIDE_W-1:0]  r_side;
    logic [csn_pkg::SIDE_W-1:0]  r_n;
    logic [csn_pkg::SQ_W-1:0]    r_n2;
    logic [6:0][csn_pkg::IDX_W-1:0] r_mul;
    logic [1:0]                  r_settle;
    logic                        w_cfg_wr;
    csn_pkg::t_cfg               w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= csn_pkg::SIDE_RESET;
            r_n      <= csn_pkg::SIDE_RESET;
            r_n2     <= csn_pkg::SQ_W'(csn_pkg::SIDE_RESET * csn_pkg::SIDE_RESET);
            for (int k = 0; k < 7; k++) begin
                r_mul[k] <= csn_pkg::IDX_W'(k * csn_pkg::SIDE_RESET * csn_pkg::SIDE_RESET);
            end
            r_settle <= 2'd0;
        end else begin
            if (w_cfg_wr) begin
                r_side   <= i_cfg_side;
                r_settle <= 2'd3;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            // side saturates at the largest face
            r_n  <= (r_side > csn_pkg::SIDE_W'(csn_pkg::MAX_SIDE)) ?
                    csn_pkg::SIDE_W'(csn_pkg::MAX_SIDE) : r_side;
            r_n2 <= csn_pkg::SQ_W'(r_n) * csn_pkg::SQ_W'(r_n);
            for (int k = 0; k < 7; k++) begin
                r_mul[k] <= csn_pkg::IDX_W'(r_n2) * csn_pkg::IDX_W'(k);
            end
        end
    end

    assign w_cfg.n   = r_n;
    assign w_cfg.mul = r_mul;

    // global pipeline advance
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en && (r_settle == 2'd0);

    csn_pkg::t_itm w_front;
    csn_pkg::t_itm w_div;

    csn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid && o_ready),
        .i_idx   (i_cell_index),
        .i_cfg   (w_cfg),
        .o_itm   (w_front)
    );

    csn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_n     (r_n),
        .i_itm   (w_front),
        .o_itm   (w_div)
    );

    csn_nbr u_nbr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_cfg         (w_cfg),
        .i_itm         (w_div),
        .o_valid       (o_valid),
        .o_face_id     (o_face_id),
        .o_col         (o_col),
        .o_row         (o_row),
        .o_north_index (o_north_index),
        .o_east_index  (o_east_index),
        .o_south_index (o_south_index),
        .o_west_index  (o_west_index),
        .o_range_error (o_range_error)
    );

endmodule

// ===== sv/csn_checker.sv =====
// port-level checks for the cube-sphere neighbor unit, bound to the top level
// depends on cube_sphere_cell_neighbors
module csn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_face_id,
    input logic [18:0] o_north_index,
    input logic [18:0] o_west_index,
    input logic        o_range_error,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped under stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_face_id == 3'd0 && o_north_index == 19'd0
            && o_west_index == 19'd0)
        else $error("error result carries nonzero fields");

    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |-> o_face_id <= 3'd5)
        else $error("face out of range");

    a_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_ready)
        else $error("request taken before side settled");

endmodule

bind cube_sphere_cell_neighbors csn_checker u_csn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_face_id     (o_face_id),
    .o_north_index (o_north_index),
    .o_west_index  (o_west_index),
    .o_range_error (o_range_error),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
